[hdl/assert_macros.svh]
// Assertion macros used by the RTL top level of the gray stretch block.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PLS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PLS_ASSERT(lbl, clk, rstn, prop, msg)
`define PLS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[hdl/pls_pkg.sv]
// Package for the piecewise linear gray stretch: widths, stage counts,
// register indexes and the payload structs passed between pipeline stages.
package pls_pkg;

  localparam int PIX_W    = 8;
  localparam int NUM_W    = 2 * PIX_W;
  // Two quotient bits per divide stage
  localparam int DIV_STG  = PIX_W / 2;
  // Select, multiply, divide stages, output
  localparam int NUM_STG  = DIV_STG + 3;
  localparam int OUT_STG  = NUM_STG - 1;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

  localparam logic [PIX_W-1:0] RST_X1 = 8'd50;
  localparam logic [PIX_W-1:0] RST_Y1 = 8'd50;
  localparam logic [PIX_W-1:0] RST_X2 = 8'd200;
  localparam logic [PIX_W-1:0] RST_Y2 = 8'd200;

  typedef enum logic [1:0] {
    REG_BREAK_ONE_IN  = 2'd0,
    REG_BREAK_ONE_OUT = 2'd1,
    REG_BREAK_TWO_IN  = 2'd2,
    REG_BREAK_TWO_OUT = 2'd3
  } pls_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] x1;
    logic [PIX_W-1:0] y1;
    logic [PIX_W-1:0] x2;
    logic [PIX_W-1:0] y2;
  } pls_cfg_t;

  // Segment selected: base level, slope magnitude, run and step
  typedef struct packed {
    logic [PIX_W-1:0] base;
    logic             neg;
    logic [PIX_W-1:0] mag;
    logic [PIX_W-1:0] dp;
    logic [PIX_W-1:0] dx;
  } pls_seg_t;

  typedef struct packed {
    logic [PIX_W-1:0] base;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] dx;
  } pls_mul_t;

  typedef struct packed {
    logic [PIX_W-1:0] base;
    logic             neg;
    logic [NUM_W-1:0] rem;
    logic [PIX_W-1:0] quot;
    logic [PIX_W-1:0] dx;
  } pls_div_t;

endpackage

[hdl/pls_if.sv]
// Valid/ready stream interfaces for the gray stretch input and result channels.
// Depends on pls_pkg for the pixel width.
interface pls_in_if;
  import pls_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pls_out_if;
  import pls_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

[hdl/piecewise_linear_gray_stretch.sv]
// Piecewise linear gray stretch: seven register stages (select, multiply,
// four divide stages of two quotient bits each, output). Throughput is one pixel
// per clock while the output is not stalled.
// Each stage loads whenever it is empty or the next one moves, so bubbles close.
// Synchronous active-low reset empties the pipeline and loads the default
// breakpoints (50,50) and (200,200).
module piecewise_linear_gray_stretch (
  input  logic                       clk,
  input  logic                       rst_n,
  pls_in_if.sink                     in_ch,
  pls_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pls_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pls_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pls_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import pls_pkg::*;
  `include "assert_macros.svh"

  pls_cfg_t           cfg;
  pls_mul_t           mul;
  pls_div_t           dv;
  logic [NUM_STG-1:0] valid_r;
  logic [NUM_STG-1:0] valid_nxt;
  logic [NUM_STG-1:0] adv;
  logic [PIX_W-1:0]   pix_r;
  logic [PIX_W-1:0]   pix_nxt;
  logic [PIX_W:0]     sum;

  pls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pls_seg u_seg (
    .clk   (clk),
    .ld    (adv[1:0]),
    .pixel (in_ch.pixel_in),
    .cfg   (cfg),
    .mul   (mul)
  );

  pls_div u_div (
    .clk  (clk),
    .ld   (adv[DIV_STG+1:2]),
    .din  (mul),
    .dout (dv)
  );

  // A stage advances when it is empty or its successor advances
  always_comb begin
    adv[OUT_STG] = !valid_r[OUT_STG] || out_ch.ready;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    if (adv[0]) begin
      valid_nxt[0] = in_ch.valid;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (adv[i]) begin
        valid_nxt[i] = valid_r[i-1];
      end
    end
  end

  // Apply the signed step to the base level and clamp to 0..255
  always_comb begin
    if (dv.neg) begin
      sum     = {1'b0, dv.base} - {1'b0, dv.quot};
      pix_nxt = sum[PIX_W] ? '0 : sum[PIX_W-1:0];
    end else begin
      sum     = {1'b0, dv.base} + {1'b0, dv.quot};
      pix_nxt = sum[PIX_W] ? LEVEL_MAX : sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) begin
      pix_r <= pix_nxt;
    end
  end

  assign in_ch.ready      = adv[0];
  assign out_ch.valid     = valid_r[OUT_STG];
  assign out_ch.pixel_out = pix_r;

  `PLS_ASSERT(a_full_blocks_input, clk, rst_n, ((&valid_r) && !out_ch.ready) |-> !in_ch.ready, "pipeline full and stalled but input ready")
  `PLS_ASSERT(a_transfer_enters, clk, rst_n, (in_ch.valid && in_ch.ready) |=> valid_r[0], "input transfer did not enter first stage")
  `PLS_ASSERT_NEVER(a_no_underflow, clk, rst_n, valid_r[DIV_STG+1] && dv.neg && (dv.quot > dv.base), "falling segment step exceeds base level")

endmodule

[hdl/pls_cfg.sv]
// APB-style breakpoint registers for the gray stretch.
// Depends on pls_pkg.
module pls_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pls_pkg::CFG_AW-1:0] paddr,
  input  logic [pls_pkg::CFG_DW-1:0] pwdata,
  output logic [pls_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output pls_pkg::pls_cfg_t         cfg
);
  import pls_pkg::*;

  pls_cfg_t   cfg_r;
  pls_cfg_t   cfg_nxt;
  pls_reg_t   idx;
  logic       wr_en;
  logic [PIX_W-1:0] rd_val;

  assign idx    = pls_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_BREAK_ONE_IN:  cfg_nxt.x1 = pwdata[PIX_W-1:0];
        REG_BREAK_ONE_OUT: cfg_nxt.y1 = pwdata[PIX_W-1:0];
        REG_BREAK_TWO_IN:  cfg_nxt.x2 = pwdata[PIX_W-1:0];
        REG_BREAK_TWO_OUT: cfg_nxt.y2 = pwdata[PIX_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BREAK_ONE_IN:  rd_val = cfg_r.x1;
      REG_BREAK_ONE_OUT: rd_val = cfg_r.y1;
      REG_BREAK_TWO_IN:  rd_val = cfg_r.x2;
      REG_BREAK_TWO_OUT: rd_val = cfg_r.y2;
      default:           rd_val = '0;
    endcase
  end

  assign prdata = {{(CFG_DW-PIX_W){1'b0}}, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{x1: RST_X1, y1: RST_Y1, x2: RST_X2, y2: RST_Y2};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/pls_seg.sv]
// Segment select and slope multiply stages of the gray stretch pipeline.
// Depends on pls_pkg.
module pls_seg (
  input  logic                     clk,
  input  logic [1:0]               ld,
  input  logic [pls_pkg::PIX_W-1:0] pixel,
  input  pls_pkg::pls_cfg_t        cfg,
  output pls_pkg::pls_mul_t        mul
);
  import pls_pkg::*;

  pls_seg_t seg_r;
  pls_seg_t seg_nxt;
  pls_mul_t mul_r;
  pls_mul_t mul_nxt;

  always_comb begin
    if (pixel <= cfg.x1) begin
      seg_nxt.base = '0;
      seg_nxt.neg  = 1'b0;
      seg_nxt.mag  = cfg.y1;
      seg_nxt.dp   = pixel;
      seg_nxt.dx   = cfg.x1;
    end else if (pixel <= cfg.x2) begin
      seg_nxt.base = cfg.y1;
      seg_nxt.neg  = cfg.y2 < cfg.y1;
      seg_nxt.mag  = (cfg.y2 < cfg.y1) ? cfg.y1 - cfg.y2 : cfg.y2 - cfg.y1;
      seg_nxt.dp   = pixel - cfg.x1;
      seg_nxt.dx   = cfg.x2 - cfg.x1;
    end else begin
      seg_nxt.base = cfg.y2;
      seg_nxt.neg  = 1'b0;
      seg_nxt.mag  = LEVEL_MAX - cfg.y2;
      seg_nxt.dp   = pixel - cfg.x2;
      seg_nxt.dx   = LEVEL_MAX - cfg.x2;
    end
    // zero-width segment: result is the base level
    if (seg_nxt.dx == '0) begin
      seg_nxt.mag = '0;
      seg_nxt.dx  = PIX_W'(1);
    end
  end

  always_comb begin
    mul_nxt.base = seg_r.base;
    mul_nxt.neg  = seg_r.neg;
    mul_nxt.num  = NUM_W'(seg_r.mag) * NUM_W'(seg_r.dp);
    mul_nxt.dx   = seg_r.dx;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      seg_r <= seg_nxt;
    end
    if (ld[1]) begin
      mul_r <= mul_nxt;
    end
  end

  assign mul = mul_r;

endmodule

[hdl/pls_div.sv]
// Pipelined restoring divider: two quotient bits per stage, eight in all.
// The numerator is below dx*256, so the quotient always fits in eight bits.
// Depends on pls_pkg.
module pls_div (
  input  logic                         clk,
  input  logic [pls_pkg::DIV_STG-1:0]  ld,
  input  pls_pkg::pls_mul_t            din,
  output pls_pkg::pls_div_t            dout
);
  import pls_pkg::*;

  pls_div_t stg_r   [DIV_STG];
  pls_div_t stg_nxt [DIV_STG];
  pls_div_t src     [DIV_STG];

  function automatic pls_div_t div_step(input pls_div_t d, input logic [2:0] sh);
    pls_div_t         r;
    logic [NUM_W-1:0] dsh;
    r   = d;
    dsh = NUM_W'(d.dx) << sh;
    if (d.rem >= dsh) begin
      r.rem      = d.rem - dsh;
      r.quot[sh] = 1'b1;
    end
    return r;
  endfunction

  assign src[0] = '{base: din.base, neg: din.neg, rem: din.num, quot: '0, dx: din.dx};

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    if (k > 0) begin : g_src
      assign src[k] = stg_r[k-1];
    end
    always_comb begin
      stg_nxt[k] = div_step(div_step(src[k], 3'(2*DIV_STG - 1 - 2*k)),
                            3'(2*DIV_STG - 2 - 2*k));
    end
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign dout = stg_r[DIV_STG-1];

endmodule

[test/tb_piecewise_linear_gray_stretch.sv]
// Testbench for the piecewise linear gray stretch: streams pixels through the
// valid/ready channels and checks each result against a local curve predictor.
// Depends on pls_pkg, the pls_in_if/pls_out_if interfaces and the RTL top level.
module tb_piecewise_linear_gray_stretch;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int IDLE_PCT     = 35;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 250;

  logic clk;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pls_in_if  in_ch ();
  pls_out_if out_ch ();

  // Predictor copy of the breakpoints
  logic [PIX_W-1:0] knee1_in;
  logic [PIX_W-1:0] knee1_out;
  logic [PIX_W-1:0] knee2_in;
  logic [PIX_W-1:0] knee2_out;

  logic [PIX_W-1:0] pending_levels[$];
  int               err_count;
  logic             calm;
  int               hold_req;

  piecewise_linear_gray_stretch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Three-segment curve through (0,0), knee1, knee2 and (255,255)
  function automatic logic [PIX_W-1:0] curve_level(input logic [PIX_W-1:0] pix);
    int x1;
    int y1;
    int x2;
    int y2;
    int p;
    int top;
    int r;
    x1  = int'(knee1_in);
    y1  = int'(knee1_out);
    x2  = int'(knee2_in);
    y2  = int'(knee2_out);
    p   = int'(pix);
    top = int'(LEVEL_MAX);
    if (p <= x1) begin
      r = (x1 > 0) ? (y1 * p) / x1 : 0;
    end else if (p <= x2) begin
      r = (x2 != x1) ? y1 + ((y2 - y1) * (p - x1)) / (x2 - x1) : y1;
    end else begin
      r = (x2 != top) ? y2 + ((top - y2) * (p - x2)) / (top - x2) : top;
    end
    if (r < 0) r = 0;
    if (r > top) r = top;
    return r[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      3:       return LEVEL_MAX;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // Mostly random pixels, a quarter of them next to a breakpoint
  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(3) != 0) return PIX_W'($urandom());
    case ($urandom_range(5))
      0:       return knee1_in - 8'd1;
      1:       return knee1_in;
      2:       return knee1_in + 8'd1;
      3:       return knee2_in - 8'd1;
      4:       return knee2_in;
      default: return knee2_in + 8'd1;
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_levels.push_back(curve_level(pix));
  endtask

  // Drop valid and hold until every pending result has been checked
  task automatic end_burst();
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic read_reg(input pls_reg_t r, input logic [PIX_W-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'({r, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata[PIX_W-1:0] !== want) begin
      $display("%0t: readback of %s: expected %0d, got %0d", $time, r.name(), want,
               cfg_prdata[PIX_W-1:0]);
      err_count++;
    end
  endtask

  // Write one register with junk in the upper bits, then read it back
  task automatic write_reg(input pls_reg_t r, input logic [PIX_W-1:0] level);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({r, 2'b00});
    cfg_pwdata  <= {(CFG_DW-PIX_W)'($urandom()), level};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (r)
      REG_BREAK_ONE_IN:  knee1_in  = level;
      REG_BREAK_ONE_OUT: knee1_out = level;
      REG_BREAK_TWO_IN:  knee2_in  = level;
      REG_BREAK_TWO_OUT: knee2_out = level;
      default:           ;
    endcase
    read_reg(r, level);
  endtask

  task automatic load_curve(input logic [PIX_W-1:0] x1, input logic [PIX_W-1:0] y1,
                            input logic [PIX_W-1:0] x2, input logic [PIX_W-1:0] y2);
    write_reg(REG_BREAK_ONE_IN, x1);
    write_reg(REG_BREAK_ONE_OUT, y1);
    write_reg(REG_BREAK_TWO_IN, x2);
    write_reg(REG_BREAK_TWO_OUT, y2);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_reset_curve();
    read_reg(REG_BREAK_ONE_IN, RST_X1);
    read_reg(REG_BREAK_ONE_OUT, RST_Y1);
    read_reg(REG_BREAK_TWO_IN, RST_X2);
    read_reg(REG_BREAK_TWO_OUT, RST_Y2);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    send_pixel(8'd0);
    send_pixel(8'd50);
    send_pixel(8'd51);
    send_pixel(8'd200);
    send_pixel(8'd201);
    send_pixel(8'd255);
    end_burst();
  endtask

  // First breakpoint at zero input, then both breakpoints pinned at the top
  task automatic test_degenerate_breaks();
    load_curve(8'd0, 8'd77, 8'd0, 8'd130);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd255);
    end_burst();
    load_curve(8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd255);
    end_burst();
  endtask

  // Second breakpoint left of the first: middle segment never taken
  task automatic test_crossed_breaks();
    load_curve(8'd180, 8'd20, 8'd60, 8'd240);
    send_pixel(8'd100);
    send_pixel(8'd181);
    send_pixel(8'd255);
    end_burst();
  endtask

  // Falling middle segment: quotient of a negative product truncates toward zero
  task automatic test_falling_middle();
    load_curve(8'd16, 8'd240, 8'd240, 8'd16);
    send_pixel(8'd16);
    send_pixel(8'd17);
    send_pixel(8'd100);
    send_pixel(8'd239);
    send_pixel(8'd240);
    send_pixel(8'd241);
    end_burst();
  endtask

  task automatic test_random_curves();
    logic [PIX_W-1:0] x1;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      x1 = pick_level();
      load_curve(x1, pick_level(), ($urandom_range(4) == 0) ? x1 : pick_level(),
                 pick_level());
      calm <= (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(pick_pixel());
      end_burst();
    end
    calm <= 1'b0;
  endtask

  // Receiver holds off while pixels keep coming, so the pipeline backs up
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) send_pixel(pick_pixel());
    end_burst();
  endtask

  task automatic test_source_pause();
    for (int i = 0; i < 20; i++) send_pixel(pick_pixel());
    end_burst();
    for (int i = 0; i < 20; i++) send_pixel(pick_pixel());
    end_burst();
  endtask

  initial begin : result_checker
    logic [PIX_W-1:0] want;
    int               hold_left;
    int               hold_taken;
    hold_left    = 0;
    hold_taken   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_levels.size() == 0) begin
          $display("%0t: unexpected pixel_out transfer: expected none, got %0d", $time,
                   out_ch.pixel_out);
          err_count++;
        end else begin
          want = pending_levels.pop_front();
          if (out_ch.pixel_out !== want) begin
            $display("%0t: pixel_out mismatch: expected %0d, got %0d", $time, want,
                     out_ch.pixel_out);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_taken) begin
        hold_taken   = hold_req;
        hold_left    = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // End the run if no transfer of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_psel === 1'b1 && cfg_penable === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.pixel_in = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    calm           = 1'b0;
    hold_req       = 0;
    err_count      = 0;
    knee1_in       = RST_X1;
    knee1_out      = RST_Y1;
    knee2_in       = RST_X2;
    knee2_out      = RST_Y2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_curve();
    test_degenerate_breaks();
    test_crossed_breaks();
    test_falling_middle();
    test_random_curves();
    test_backpressure();
    test_source_pause();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/pls_pkg.sv
hdl/pls_if.sv
hdl/pls_cfg.sv
hdl/pls_seg.sv
hdl/pls_div.sv
hdl/piecewise_linear_gray_stretch.sv
test/tb_piecewise_linear_gray_stretch.sv
